// ===== hdl/allm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package allm_pkg;

    typedef enum logic [2:0] {
        CMD_INS_AFTER  = 3'd0,
        CMD_INS_BEFORE = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_POSITION   = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_FULL        = 3'd1,
        STS_ANCHOR_FREE = 3'd2,
        STS_EMPTY       = 3'd3,
        STS_RANGE       = 3'd4,
        STS_NOT_FOUND   = 3'd5
    } t_status;

    typedef struct packed {
        t_cmd        command;
        logic [9:0]  anchor_slot;
        logic [31:0] value;
        logic [9:0]  position;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [9:0]  slot;
        logic [31:0] data;
    } t_resp;

endpackage

`default_nettype wire

// ===== hdl/array_linked_list_manager.sv =====
// Insert steps through INS1, INS2 and INS3, remove through REM1 and REM2, clear through the CLR sweep.
// Position lookup and find walk the list from its head, one link per cycle,
// paced by the registered read of the link memories.
// A new request is accepted only after the previous result has been registered for output.
// After reset the block sweeps all CAPACITY+1 slots, one per cycle, before it takes a request;
// a clear request runs the same sweep.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_manager #(
    parameter int CAPACITY  = 1023,
    parameter int DATA_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire allm_pkg::t_req  i_in_req,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output allm_pkg::t_resp      o_out_resp
);

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int AW = (SW > 10) ? SW : 10;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_INS1  = 12'b0000_0000_0010,
        ST_INS2  = 12'b0000_0000_0100,
        ST_INS3  = 12'b0000_0000_1000,
        ST_REM1  = 12'b0000_0001_0000,
        ST_REM2  = 12'b0000_0010_0000,
        ST_POS   = 12'b0000_0100_0000,
        ST_POSD  = 12'b0000_1000_0000,
        ST_FINDS = 12'b0001_0000_0000,
        ST_FIND  = 12'b0010_0000_0000,
        ST_CLR   = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } t_state;

    logic [SW-1:0]        m_nxt [0:CAPACITY];
    logic [SW-1:0]        m_prv [0:CAPACITY];
    logic                 m_use [0:CAPACITY];
    logic [DATA_BITS-1:0] m_dat [0:CAPACITY];

    logic [SW-1:0]        rd_nxt, rd_prv;
    logic                 rd_use;
    logic [DATA_BITS-1:0] rd_dat;

    t_state               r_state, n_state;
    allm_pkg::t_cmd       r_cmd, n_cmd;
    logic [SW-1:0]        r_a, n_a;
    logic                 r_aok, n_aok;
    logic [DATA_BITS-1:0] r_val, n_val;
    logic [SW-1:0]        r_cnt, n_cnt;
    logic [SW-1:0]        r_cur, n_cur;
    logic [SW-1:0]        r_pv, n_pv;
    logic [SW-1:0]        r_nx, n_nx;
    logic [SW-1:0]        r_fh, n_fh;
    logic [SW-1:0]        r_count, n_count;
    logic [SW-1:0]        r_clr_idx, n_clr_idx;
    logic                 r_clr_emit, n_clr_emit;
    allm_pkg::t_resp      r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    allm_pkg::t_resp      r_out, n_out;

    logic [SW-1:0]        w_raddr;
    logic                 wn_en, wp_en, wu_en, wd_en;
    logic [SW-1:0]        wn_addr, wp_addr, wu_addr, wd_addr;
    logic [SW-1:0]        wn_data, wp_data;
    logic                 wu_data;
    logic                 w_accept;
    logic [AW-1:0]        w_anchor_wide;
    logic                 w_anchor_ok;
    logic [SW-1:0]        w_walk;

    function automatic logic [SW-1:0] fix_idx(input logic [SW-1:0] x);
        return (x <= SW'(CAPACITY)) ? x : '0;
    endfunction

    function automatic allm_pkg::t_resp make_res(input allm_pkg::t_status st,
                                                 input logic [SW-1:0] sl,
                                                 input logic [DATA_BITS-1:0] d);
        allm_pkg::t_resp res;
        res.status = st;
        res.slot   = 10'(sl);
        res.data   = 32'(d);
        return res;
    endfunction

    assign o_in_stall    = (r_state != ST_IDLE);
    assign w_accept      = i_in_valid && (r_state == ST_IDLE);
    assign w_anchor_wide = AW'(i_in_req.anchor_slot);
    assign w_anchor_ok   = (w_anchor_wide <= AW'(CAPACITY));
    assign w_walk        = fix_idx(rd_nxt);
    assign o_out_valid   = r_out_valid;
    assign o_out_resp    = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_a         = r_a;
        n_aok       = r_aok;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_pv        = r_pv;
        n_nx        = r_nx;
        n_fh        = r_fh;
        n_count     = r_count;
        n_clr_idx   = r_clr_idx;
        n_clr_emit  = r_clr_emit;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_raddr     = '0;
        wn_en       = 1'b0;
        wp_en       = 1'b0;
        wu_en       = 1'b0;
        wd_en       = 1'b0;
        wn_addr     = '0;
        wp_addr     = '0;
        wu_addr     = '0;
        wd_addr     = '0;
        wn_data     = '0;
        wp_data     = '0;
        wu_data     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_in_req.command;
                    n_a   = w_anchor_ok ? SW'(w_anchor_wide) : '0;
                    n_aok = w_anchor_ok;
                    n_val = DATA_BITS'(i_in_req.value);
                    case (i_in_req.command)
                        allm_pkg::CMD_INS_AFTER, allm_pkg::CMD_INS_BEFORE: begin
                            w_raddr = w_anchor_ok ? SW'(w_anchor_wide) : '0;
                            n_state = ST_INS1;
                        end
                        allm_pkg::CMD_REMOVE: begin
                            w_raddr = w_anchor_ok ? SW'(w_anchor_wide) : '0;
                            n_state = ST_REM1;
                        end
                        allm_pkg::CMD_POSITION: begin
                            if (AW'(i_in_req.position) >= AW'(r_count)) begin
                                n_res   = make_res(allm_pkg::STS_RANGE, '0, '0);
                                n_state = ST_DONE;
                            end else begin
                                n_cnt   = SW'(i_in_req.position);
                                n_state = ST_POS;
                            end
                        end
                        allm_pkg::CMD_FIND: begin
                            n_state = ST_FINDS;
                        end
                        allm_pkg::CMD_CLEAR: begin
                            n_clr_idx  = '0;
                            n_clr_emit = 1'b1;
                            n_state    = ST_CLR;
                        end
                        default: begin
                            n_res   = make_res(allm_pkg::STS_OK, '0, '0);
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS1: begin
                if (!(r_aok && rd_use)) begin
                    n_res   = make_res(allm_pkg::STS_ANCHOR_FREE, '0, '0);
                    n_state = ST_DONE;
                end else if (r_fh == '0 || r_count >= SW'(CAPACITY)) begin
                    n_res   = make_res(allm_pkg::STS_FULL, '0, '0);
                    n_state = ST_DONE;
                end else begin
                    n_cur = r_fh;
                    if (r_cmd == allm_pkg::CMD_INS_AFTER) begin
                        n_pv = r_a;
                        n_nx = fix_idx(rd_nxt);
                    end else begin
                        n_pv = fix_idx(rd_prv);
                        n_nx = r_a;
                    end
                    w_raddr = r_fh;
                    wp_en   = 1'b1;
                    wp_addr = r_fh;
                    wp_data = n_pv;
                    wu_en   = 1'b1;
                    wu_addr = r_fh;
                    wu_data = 1'b1;
                    wd_en   = 1'b1;
                    wd_addr = r_fh;
                    n_state = ST_INS2;
                end
            end
            ST_INS2: begin
                n_fh    = fix_idx(rd_nxt);
                wn_en   = 1'b1;
                wn_addr = r_cur;
                wn_data = r_nx;
                wp_en   = 1'b1;
                wp_addr = r_nx;
                wp_data = r_cur;
                n_state = ST_INS3;
            end
            ST_INS3: begin
                wn_en   = 1'b1;
                wn_addr = r_pv;
                wn_data = r_cur;
                n_count = r_count + 1'b1;
                n_res   = make_res(allm_pkg::STS_OK, r_cur, '0);
                n_state = ST_DONE;
            end
            ST_REM1: begin
                if (r_count == '0) begin
                    n_res   = make_res(allm_pkg::STS_EMPTY, '0, '0);
                    n_state = ST_DONE;
                end else if (r_a == '0 || !(r_aok && rd_use)) begin
                    n_res   = make_res(allm_pkg::STS_ANCHOR_FREE, '0, '0);
                    n_state = ST_DONE;
                end else begin
                    wp_en   = 1'b1;
                    wp_addr = fix_idx(rd_nxt);
                    wp_data = fix_idx(rd_prv);
                    wn_en   = 1'b1;
                    wn_addr = fix_idx(rd_prv);
                    wn_data = fix_idx(rd_nxt);
                    wu_en   = 1'b1;
                    wu_addr = r_a;
                    wu_data = 1'b0;
                    n_state = ST_REM2;
                end
            end
            ST_REM2: begin
                wp_en   = 1'b1;
                wp_addr = r_a;
                wp_data = '0;
                wn_en   = 1'b1;
                wn_addr = r_a;
                wn_data = r_fh;
                n_fh    = r_a;
                n_count = r_count - 1'b1;
                n_res   = make_res(allm_pkg::STS_OK, r_a, '0);
                n_state = ST_DONE;
            end
            ST_POS: begin
                w_raddr = w_walk;
                n_cur   = w_walk;
                if (r_cnt == '0) begin
                    n_state = ST_POSD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_POSD: begin
                n_res   = make_res(allm_pkg::STS_OK, r_cur, rd_dat);
                n_state = ST_DONE;
            end
            ST_FINDS: begin
                if (r_count == '0) begin
                    n_res   = make_res(allm_pkg::STS_NOT_FOUND, '0, '0);
                    n_state = ST_DONE;
                end else begin
                    w_raddr = w_walk;
                    n_cur   = w_walk;
                    n_cnt   = SW'(1);
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                if (rd_dat == r_val) begin
                    n_res   = make_res(allm_pkg::STS_OK, r_cur, rd_dat);
                    n_state = ST_DONE;
                end else if (r_cnt == r_count) begin
                    n_res   = make_res(allm_pkg::STS_NOT_FOUND, '0, '0);
                    n_state = ST_DONE;
                end else begin
                    w_raddr = w_walk;
                    n_cur   = w_walk;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            ST_CLR: begin
                wn_en   = 1'b1;
                wn_addr = r_clr_idx;
                wn_data = (r_clr_idx == '0 || r_clr_idx == SW'(CAPACITY)) ?
                          '0 : r_clr_idx + 1'b1;
                wp_en   = 1'b1;
                wp_addr = r_clr_idx;
                wp_data = '0;
                wu_en   = 1'b1;
                wu_addr = r_clr_idx;
                wu_data = (r_clr_idx == '0);
                n_fh    = SW'(1);
                n_count = '0;
                if (r_clr_idx == SW'(CAPACITY)) begin
                    n_res   = make_res(allm_pkg::STS_OK, '0, '0);
                    n_state = r_clr_emit ? ST_DONE : ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        rd_nxt <= m_nxt[w_raddr];
        rd_prv <= m_prv[w_raddr];
        rd_use <= m_use[w_raddr];
        rd_dat <= m_dat[w_raddr];
        if (wn_en) begin
            m_nxt[wn_addr] <= wn_data;
        end
        if (wp_en) begin
            m_prv[wp_addr] <= wp_data;
        end
        if (wu_en) begin
            m_use[wu_addr] <= wu_data;
        end
        if (wd_en) begin
            m_dat[wd_addr] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_idx   <= '0;
            r_clr_emit  <= 1'b0;
            r_fh        <= SW'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_emit  <= n_clr_emit;
            r_fh        <= n_fh;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_a   <= n_a;
        r_aok <= n_aok;
        r_val <= n_val;
        r_cnt <= n_cnt;
        r_cur <= n_cur;
        r_pv  <= n_pv;
        r_nx  <= n_nx;
        r_res <= n_res;
        r_out <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(CAPACITY))
        else $error("element count above capacity");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the completion state");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS3) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance the element count");

    a_remove_free_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REM2) |=> (r_fh == $past(r_a)))
        else $error("removed slot is not the new free head");

endmodule

`default_nettype wire

// ===== bench/tb_array_linked_list_manager.sv =====
`timescale 1ns / 1ps

class ListScoreboard;
    localparam int CAP = 1023;

    logic [9:0]  next_link [0:CAP];
    logic [9:0]  prev_link [0:CAP];
    logic [31:0] slot_data [0:CAP];
    bit          slot_used [0:CAP];
    logic [9:0]  free_head;
    int          element_count;
    allm_pkg::t_resp pending [$];
    int          errors;
    int          checked;

    function new();
        errors = 0;
        checked = 0;
        clear_lists();
    endfunction

    function void clear_lists();
        for (int i = 0; i <= CAP; i++) begin
            next_link[i] = (i == 0 || i == CAP) ? 10'd0 : 10'(i + 1);
            prev_link[i] = 10'd0;
            slot_data[i] = 32'd0;
            slot_used[i] = (i == 0);
        end
        free_head = 10'd1;
        element_count = 0;
    endfunction

    function bit is_live(logic [9:0] a);
        return a <= CAP && slot_used[a];
    endfunction

    function void note_request(allm_pkg::t_req r);
        allm_pkg::t_resp e;
        logic [9:0] nw, nx, pv, cur;
        e = '{status: allm_pkg::STS_OK, slot: 10'd0, data: 32'd0};
        case (r.command)
            allm_pkg::CMD_INS_AFTER, allm_pkg::CMD_INS_BEFORE: begin
                if (!is_live(r.anchor_slot)) begin
                    e.status = allm_pkg::STS_ANCHOR_FREE;
                end else if (free_head == 0 || element_count >= CAP) begin
                    e.status = allm_pkg::STS_FULL;
                end else begin
                    nw = free_head;
                    free_head = next_link[nw];
                    slot_data[nw] = r.value;
                    slot_used[nw] = 1'b1;
                    if (r.command == allm_pkg::CMD_INS_AFTER) begin
                        pv = r.anchor_slot;
                        nx = next_link[r.anchor_slot];
                    end else begin
                        pv = prev_link[r.anchor_slot];
                        nx = r.anchor_slot;
                    end
                    next_link[nw] = nx;
                    prev_link[nw] = pv;
                    next_link[pv] = nw;
                    prev_link[nx] = nw;
                    element_count++;
                    e.slot = nw;
                end
            end
            allm_pkg::CMD_REMOVE: begin
                if (element_count == 0) begin
                    e.status = allm_pkg::STS_EMPTY;
                end else if (r.anchor_slot == 0 || !is_live(r.anchor_slot)) begin
                    e.status = allm_pkg::STS_ANCHOR_FREE;
                end else begin
                    nx = next_link[r.anchor_slot];
                    pv = prev_link[r.anchor_slot];
                    prev_link[nx] = pv;
                    next_link[pv] = nx;
                    slot_data[r.anchor_slot] = 32'd0;
                    slot_used[r.anchor_slot] = 1'b0;
                    prev_link[r.anchor_slot] = 10'd0;
                    next_link[r.anchor_slot] = free_head;
                    free_head = r.anchor_slot;
                    element_count--;
                    e.slot = r.anchor_slot;
                end
            end
            allm_pkg::CMD_POSITION: begin
                if (r.position >= element_count) begin
                    e.status = allm_pkg::STS_RANGE;
                end else begin
                    cur = next_link[0];
                    for (int i = 0; i < r.position; i++) cur = next_link[cur];
                    e.slot = cur;
                    e.data = slot_data[cur];
                end
            end
            allm_pkg::CMD_FIND: begin
                e.status = allm_pkg::STS_NOT_FOUND;
                cur = next_link[0];
                for (int i = 0; i < element_count; i++) begin
                    if (slot_data[cur] == r.value) begin
                        e.status = allm_pkg::STS_OK;
                        e.slot = cur;
                        e.data = slot_data[cur];
                        break;
                    end
                    cur = next_link[cur];
                end
            end
            allm_pkg::CMD_CLEAR: clear_lists();
            default: ;
        endcase
        pending.push_back(e);
    endfunction

    function void check_result(allm_pkg::t_resp got);
        allm_pkg::t_resp e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
        end
        if (got.slot !== e.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, e.slot, got.slot);
            errors++;
        end
        if (got.data !== e.data) begin
            $display("%0t: data expected %h actual %h", $time, e.data, got.data);
            errors++;
        end
    endfunction

    function logic [9:0] random_live();
        logic [9:0] cur;
        int n;
        if (element_count == 0) return 10'd0;
        n = $urandom_range(element_count - 1);
        cur = next_link[0];
        for (int i = 0; i < n; i++) cur = next_link[cur];
        return cur;
    endfunction

    function logic [31:0] random_stored();
        return slot_data[random_live()];
    endfunction
endclass

module tb_array_linked_list_manager;
    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    allm_pkg::t_req  i_in_req;
    logic  o_out_valid;
    logic  i_out_stall;
    allm_pkg::t_resp o_out_resp;

    ListScoreboard lists;
    int send_idle_pct;
    int stall_pct;
    int op_mix;
    int sent;

    array_linked_list_manager DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_req(i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_resp(o_out_resp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) lists.check_result(o_out_resp);
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_request(allm_pkg::t_cmd c, logic [9:0] a, logic [31:0] v,
                                logic [9:0] p);
        allm_pkg::t_req r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        r = '{command: c, anchor_slot: a, value: v, position: p};
        i_in_valid <= 1'b1;
        i_in_req <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lists.note_request(r);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (lists.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_request();
        int k;
        logic [9:0] a;
        logic [31:0] v;
        k = $urandom_range(99);
        a = ($urandom_range(9) == 0) ? 10'($urandom) : lists.random_live();
        v = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(15));
        if (k < op_mix) begin
            send_request($urandom_range(1) ? allm_pkg::CMD_INS_AFTER
                                           : allm_pkg::CMD_INS_BEFORE,
                a, v, 10'($urandom));
        end else if (k < 75) begin
            send_request(allm_pkg::CMD_REMOVE, a, v, 10'($urandom));
        end else if (k < 87) begin
            send_request(allm_pkg::CMD_POSITION, a, v, ($urandom_range(7) == 0) ? 10'($urandom)
                : 10'($urandom_range(lists.element_count + 1)));
        end else if (k < 98) begin
            send_request(allm_pkg::CMD_FIND, a, ($urandom_range(1) ? lists.random_stored() : v),
                10'($urandom));
        end else if (k == 98) begin
            send_request(allm_pkg::t_cmd'(3'($urandom_range(7, 6))), a, v, 10'($urandom));
        end else begin
            send_request(allm_pkg::CMD_CLEAR, a, v, 10'($urandom));
        end
    endtask

    initial begin
        lists = new();
        sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        op_mix = 45;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_in_req = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(allm_pkg::CMD_REMOVE, 10'd1, 32'd0, 10'd0);
        send_request(allm_pkg::CMD_POSITION, 10'd0, 32'd0, 10'd0);
        send_request(allm_pkg::CMD_FIND, 10'd0, 32'd0, 10'd0);
        send_request(allm_pkg::CMD_INS_AFTER, 10'd5, 32'h1, 10'd0);
        send_request(allm_pkg::CMD_INS_AFTER, 10'd1023, 32'h1, 10'd0);
        send_request(allm_pkg::CMD_INS_AFTER, 10'd0, 32'hFFFF_FFFF, 10'd0);
        send_request(allm_pkg::CMD_INS_BEFORE, 10'd0, 32'h0, 10'd0);
        send_request(allm_pkg::CMD_INS_AFTER, 10'd1, 32'hA5A5_5A5A, 10'd1023);
        send_request(allm_pkg::CMD_INS_BEFORE, 10'd2, 32'h5A5A_A5A5, 10'd0);
        send_request(allm_pkg::CMD_POSITION, 10'd0, 32'd0, 10'd3);
        send_request(allm_pkg::CMD_POSITION, 10'd0, 32'd0, 10'd4);
        send_request(allm_pkg::CMD_POSITION, 10'd0, 32'd0, 10'd1023);
        send_request(allm_pkg::CMD_FIND, 10'd0, 32'h5A5A_A5A5, 10'd0);
        send_request(allm_pkg::CMD_FIND, 10'd0, 32'h1234_5678, 10'd0);
        send_request(allm_pkg::CMD_REMOVE, 10'd0, 32'd0, 10'd0);
        send_request(allm_pkg::CMD_REMOVE, 10'd1023, 32'd0, 10'd0);
        send_request(allm_pkg::CMD_REMOVE, 10'd1, 32'd0, 10'd0);
        send_request(allm_pkg::CMD_REMOVE, 10'd1, 32'd0, 10'd0);
        send_request(allm_pkg::t_cmd'(3'd6), 10'd0, 32'd0, 10'd0);
        send_request(allm_pkg::t_cmd'(3'd7), 10'd1023, 32'hFFFF_FFFF, 10'd1023);
        send_request(allm_pkg::CMD_CLEAR, 10'd0, 32'd0, 10'd0);
        send_request(allm_pkg::CMD_POSITION, 10'd0, 32'd0, 10'd0);
        drain();

        // Fill to capacity so that full and the last slot are reached.
        for (int i = 0; i < 1025; i++) begin
            send_request(allm_pkg::CMD_INS_BEFORE, 10'd0, $urandom, 10'd0);
        end
        send_request(allm_pkg::CMD_POSITION, 10'd0, 32'd0, 10'd1022);
        send_request(allm_pkg::CMD_REMOVE, 10'd1023, 32'd0, 10'd0);
        send_request(allm_pkg::CMD_CLEAR, 10'd0, 32'd0, 10'd0);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 80 : 25) : 0;
            stall_pct = (ph == 2) ? 80 : ((ph == 3) ? 25 : 0);
            op_mix = (ph % 2 == 0) ? 55 : 40;
            for (int i = 0; i < 240; i++) random_request();
            drain();
        end

        i_in_valid <= 1'b0;
        repeat (2100) @(posedge i_clk);
        $display("Sent %0d requests, %0d results checked, fill to capacity and four pacing phases.",
            sent, lists.checked);
        if (lists.errors == 0 && lists.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
